// File: hdl/lagu_pkg.sv
// Package for the life automaton grid unit: sizes, item codes, register
// indexes, memory request types and helpers for the grid in use.
// No dependencies.
`default_nettype none

package lagu_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CFG_W    = 7;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;

  localparam logic CFG_ROWS_IN_USE = 1'b0;
  localparam logic CFG_COLS_IN_USE = 1'b1;

  typedef logic [MAX_COLS-1:0] row_bits_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
  } mem_rd_req_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
    row_bits_t        data;
  } mem_wr_req_t;

  function automatic logic [CFG_W-1:0] eff_rows_f(input logic [CFG_W-1:0] val);
    logic [CFG_W-1:0] res;
    if (val == '0) begin
      res = CFG_W'(1);
    end else if (val > CFG_W'(MAX_ROWS)) begin
      res = CFG_W'(MAX_ROWS);
    end else begin
      res = val;
    end
    return res;
  endfunction

  function automatic logic [CFG_W-1:0] eff_cols_f(input logic [CFG_W-1:0] val);
    logic [CFG_W-1:0] res;
    if (val == '0) begin
      res = CFG_W'(1);
    end else if (val > CFG_W'(MAX_COLS)) begin
      res = CFG_W'(MAX_COLS);
    end else begin
      res = val;
    end
    return res;
  endfunction

  function automatic row_bits_t col_mask_f(input logic [CFG_W-1:0] cols);
    row_bits_t m;
    for (int c = 0; c < MAX_COLS; c++) begin
      m[c] = (CFG_W'(c) < cols);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hdl/lagu_row_mem.sv
// Row store of the grid: one row per entry, one write and one read port,
// read data registered. Per-row valid bits make unwritten rows read as dead.
// Depends on lagu_pkg.
`default_nettype none

module lagu_row_mem
  import lagu_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  mem_rd_req_t rd_req_i,
  input  mem_wr_req_t wr_req_i,
  output row_bits_t   rd_data_o
);

  row_bits_t             mem_q [MAX_ROWS];
  logic [MAX_ROWS-1:0]   valid_q;
  row_bits_t             rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) begin
      mem_q[wr_req_i.addr] <= wr_req_i.data;
    end
    if (rd_req_i.en) begin
      rd_data_q <= valid_q[rd_req_i.addr] ? mem_q[rd_req_i.addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_req_i.en) begin
      valid_q[wr_req_i.addr] <= 1'b1;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: hdl/lagu_row_rule.sv
// Next generation of one grid row under rule B3/S23, all columns in parallel.
// Depends on lagu_pkg.
`default_nettype none

module lagu_row_rule
  import lagu_pkg::*;
(
  input  row_bits_t up_i,
  input  row_bits_t mid_i,
  input  row_bits_t down_i,
  output row_bits_t next_o
);

  logic [MAX_COLS+1:0] up_pad;
  logic [MAX_COLS+1:0] mid_pad;
  logic [MAX_COLS+1:0] down_pad;
  logic [3:0]          count [MAX_COLS];

  assign up_pad   = {1'b0, up_i, 1'b0};
  assign mid_pad  = {1'b0, mid_i, 1'b0};
  assign down_pad = {1'b0, down_i, 1'b0};

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      count[c] = 4'(up_pad[c])   + 4'(up_pad[c+1])   + 4'(up_pad[c+2])
               + 4'(mid_pad[c])                      + 4'(mid_pad[c+2])
               + 4'(down_pad[c]) + 4'(down_pad[c+1]) + 4'(down_pad[c+2]);
      next_o[c] = (count[c] == 4'd3) || ((count[c] == 4'd2) && mid_i[c]);
    end
  end

endmodule

`default_nettype wire

// File: hdl/life_automaton_grid_unit.sv
// Top level of the life automaton grid unit: request sequencer, grid
// configuration and result register. Depends on lagu_pkg, lagu_row_mem
// and lagu_row_rule.
`default_nettype none

// The slave stream takes one request per handshake: a cell write, a cell read
// or a one-generation advance of the grid in use. Every request yields exactly
// one result on the master stream, holding the cell read and whether the
// addressed cell lies inside the grid in use.
// A request is taken only while the sequencer is idle. A cell read or write
// goes through a read-modify-write of its row in the row store; it passes
// the cell state and then the done state, from which its result is loaded
// into the output register. An advance reads the rows in use one per cycle
// from the single read port of the row store and writes each new row back
// as soon as the row below it has arrived. The next request is taken in the
// cycle after the result has been loaded into the output register.
// When the receiver stalls, the result waits in the output register and the
// block can still accept and execute one more request; it then holds that
// result until the output register frees up.
// Reset clears all cells to dead through per-row valid bits, so no clearing
// pass is needed; both size registers return to 64. Size registers are to be
// written only while no request is outstanding.

module life_automaton_grid_unit
  import lagu_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  [15:0]       s_axis_tdata,  // kind[1:0], row[7:2], col[13:8], alive_in[14]
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // alive_out[0], in_range[1]
  input  wire               cfg_we_i,
  input  wire               cfg_idx_i,
  input  wire  [CFG_W-1:0]  cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CELL = 2'd1;
  localparam logic [1:0] ST_ADV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CFG_W-1:0] rows_cfg_q, cols_cfg_q;
  logic             out_valid_q, out_valid_d;
  logic             out_alive_q, out_alive_d;
  logic             out_range_q, out_range_d;
  logic             pend_q, pend_d;
  logic [CFG_W-1:0] pend_row_q, pend_row_d;
  logic [CFG_W-1:0] rd_ptr_q, rd_ptr_d;

  logic [1:0]       kind_q, kind_d;
  logic [5:0]       row_q, row_d;
  logic [5:0]       col_q, col_d;
  logic             alive_q, alive_d;
  logic             ok_q, ok_d;
  logic             res_alive_q, res_alive_d;
  row_bits_t        up_q, up_d;
  row_bits_t        mid_q, mid_d;

  logic [1:0]       in_kind;
  logic [5:0]       in_row;
  logic [5:0]       in_col;
  logic             in_alive;
  logic             in_accept;
  logic [CFG_W-1:0] rows_eff;
  logic [CFG_W-1:0] cols_eff;
  row_bits_t        mask;
  row_bits_t        rd_data;
  row_bits_t        cell_bit;
  row_bits_t        rule_down;
  row_bits_t        rule_next;
  mem_rd_req_t      rd_req;
  mem_wr_req_t      wr_req;

  assign in_kind   = s_axis_tdata[1:0];
  assign in_row    = s_axis_tdata[7:2];
  assign in_col    = s_axis_tdata[13:8];
  assign in_alive  = s_axis_tdata[14];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign rows_eff  = eff_rows_f(rows_cfg_q);
  assign cols_eff  = eff_cols_f(cols_cfg_q);
  assign mask      = col_mask_f(cols_eff);
  assign cell_bit  = MAX_COLS'(1) << col_q[COL_W-1:0];
  assign rule_down = pend_q ? (rd_data & mask) : '0;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_range_q, out_alive_q};

  lagu_row_mem u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_req_i  (rd_req),
    .wr_req_i  (wr_req),
    .rd_data_o (rd_data)
  );

  lagu_row_rule u_row_rule (
    .up_i   (up_q),
    .mid_i  (mid_q & mask),
    .down_i (rule_down),
    .next_o (rule_next)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_alive_d = out_alive_q;
    out_range_d = out_range_q;
    pend_d      = pend_q;
    pend_row_d  = pend_row_q;
    rd_ptr_d    = rd_ptr_q;
    kind_d      = kind_q;
    row_d       = row_q;
    col_d       = col_q;
    alive_d     = alive_q;
    ok_d        = ok_q;
    res_alive_d = res_alive_q;
    up_d        = up_q;
    mid_d       = mid_q;
    rd_req      = '0;
    wr_req      = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          kind_d      = in_kind;
          row_d       = in_row;
          col_d       = in_col;
          alive_d     = in_alive;
          ok_d        = ({1'b0, in_row} < rows_eff) && ({1'b0, in_col} < cols_eff);
          res_alive_d = 1'b0;
          if (in_kind == KIND_WRITE || in_kind == KIND_READ) begin
            rd_req.en   = 1'b1;
            rd_req.addr = ROW_W'(in_row);
            state_d     = ST_CELL;
          end else if (in_kind == KIND_ADVANCE) begin
            rd_req.en   = 1'b1;
            rd_req.addr = '0;
            rd_ptr_d    = CFG_W'(1);
            pend_d      = 1'b1;
            pend_row_d  = '0;
            up_d        = '0;
            mid_d       = '0;
            state_d     = ST_ADV;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CELL: begin
        if (kind_q == KIND_WRITE && ok_q) begin
          wr_req.en   = 1'b1;
          wr_req.addr = ROW_W'(row_q);
          wr_req.data = alive_q ? (rd_data | cell_bit) : (rd_data & ~cell_bit);
        end
        res_alive_d = (kind_q == KIND_READ) && ok_q && rd_data[col_q[COL_W-1:0]];
        state_d     = ST_DONE;
      end
      ST_ADV: begin
        if (rd_ptr_q < rows_eff) begin
          rd_req.en   = 1'b1;
          rd_req.addr = rd_ptr_q[ROW_W-1:0];
          rd_ptr_d    = rd_ptr_q + CFG_W'(1);
          pend_d      = 1'b1;
          pend_row_d  = rd_ptr_q;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (pend_row_q != '0) begin
            wr_req.en   = 1'b1;
            wr_req.addr = ROW_W'(pend_row_q - CFG_W'(1));
            wr_req.data = (rule_next & mask) | (mid_q & ~mask);
          end
          up_d  = mid_q & mask;
          mid_d = rd_data;
        end else begin
          // Last row: nothing below it.
          wr_req.en   = 1'b1;
          wr_req.addr = ROW_W'(rows_eff - CFG_W'(1));
          wr_req.data = (rule_next & mask) | (mid_q & ~mask);
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_alive_d = res_alive_q;
          out_range_d = ok_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      pend_row_q  <= '0;
      rd_ptr_q    <= '0;
      rows_cfg_q  <= CFG_W'(MAX_ROWS);
      cols_cfg_q  <= CFG_W'(MAX_COLS);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      pend_row_q  <= pend_row_d;
      rd_ptr_q    <= rd_ptr_d;
      if (cfg_we_i && cfg_idx_i == CFG_ROWS_IN_USE) begin
        rows_cfg_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_COLS_IN_USE) begin
        cols_cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_alive_q <= out_alive_d;
    out_range_q <= out_range_d;
    kind_q      <= kind_d;
    row_q       <= row_d;
    col_q       <= col_d;
    alive_q     <= alive_d;
    ok_q        <= ok_d;
    res_alive_q <= res_alive_d;
    up_q        <= up_d;
    mid_q       <= mid_d;
  end

endmodule

`default_nettype wire
